FILE: rtl/core/irn_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// irn_pkg
// Shared types, constants and lookup functions of the Roman numeral converter.
// ----------------------------------------------------------------------------
package irn_pkg;

   // Request queue between the front and the back.
   localparam int FifoDepth = 4;
   localparam int FifoPtrW  = $clog2(FifoDepth);
   localparam int FifoCntW  = $clog2(FifoDepth + 1);

   // Numbers at or above this limit are reported as errors.
   localparam logic [15:0] NumLimit = 16'd4000;

   // Decimal places, in emission order.
   localparam logic [1:0] PlaceThou = 2'd0;
   localparam logic [1:0] PlaceHund = 2'd1;
   localparam logic [1:0] PlaceTens = 2'd2;
   localparam logic [1:0] PlaceUnit = 2'd3;
   localparam int         NumPlaces = 4;

   // Letter roles inside a digit pattern.
   localparam logic [1:0] CodeNone = 2'd0;
   localparam logic [1:0] CodeOne  = 2'd1;
   localparam logic [1:0] CodeFive = 2'd2;
   localparam logic [1:0] CodeTen  = 2'd3;

   // ASCII letters.
   localparam logic [7:0] SymI   = 8'h49;
   localparam logic [7:0] SymV   = 8'h56;
   localparam logic [7:0] SymX   = 8'h58;
   localparam logic [7:0] SymL   = 8'h4C;
   localparam logic [7:0] SymC   = 8'h43;
   localparam logic [7:0] SymD   = 8'h44;
   localparam logic [7:0] SymM   = 8'h4D;
   localparam logic [7:0] SymErr = 8'h00;

   // One classified request: the decimal digits, or the error flag.
   typedef struct packed {
      logic       err;
      logic [1:0] thou;
      logic [3:0] hund;
      logic [3:0] tens;
      logic [3:0] unit;
   } desc_type;

   // Number of letters that one lower digit produces.
   function automatic logic [2:0] digit_len(input logic [3:0] d);
      logic [2:0] len;
      case (d)
         4'd1, 4'd5:       len = 3'd1;
         4'd2, 4'd4, 4'd6: len = 3'd2;
         4'd9:             len = 3'd2;
         4'd3, 4'd7:       len = 3'd3;
         4'd8:             len = 3'd4;
         default:          len = 3'd0;
      endcase
      return len;
   endfunction

   // Letter role at step j of the pattern of digit d.
   function automatic logic [1:0] digit_code(input logic [3:0] d, input logic [1:0] j);
      logic [1:0] code;
      case (d)
         4'd1, 4'd2, 4'd3:       code = CodeOne;
         4'd4:                   code = (j == 2'd0) ? CodeOne : CodeFive;
         4'd5, 4'd6, 4'd7, 4'd8: code = (j == 2'd0) ? CodeFive : CodeOne;
         4'd9:                   code = (j == 2'd0) ? CodeOne : CodeTen;
         default:                code = CodeNone;
      endcase
      return code;
   endfunction

   // ASCII letter for a role at a place.
   function automatic logic [7:0] place_letter(input logic [1:0] place,
                                               input logic [1:0] code);
      logic [7:0] sym;
      sym = SymErr;
      case (place)
         PlaceThou: sym = SymM;
         PlaceHund: begin
            case (code)
               CodeOne:  sym = SymC;
               CodeFive: sym = SymD;
               CodeTen:  sym = SymM;
               default:  sym = SymErr;
            endcase
         end
         PlaceTens: begin
            case (code)
               CodeOne:  sym = SymX;
               CodeFive: sym = SymL;
               CodeTen:  sym = SymC;
               default:  sym = SymErr;
            endcase
         end
         PlaceUnit: begin
            case (code)
               CodeOne:  sym = SymI;
               CodeFive: sym = SymV;
               CodeTen:  sym = SymX;
               default:  sym = SymErr;
            endcase
         end
         default: sym = SymErr;
      endcase
      return sym;
   endfunction

endpackage

FILE: rtl/core/integer_to_roman_numeral.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// integer_to_roman_numeral
// Converts an unsigned number into its Roman numeral, one ASCII letter per
// response, with the final letter flagged.
//
//   Channel  Direction  Handshake              Payload
//   req      in         req_valid/req_ready    req_number[15:0]
//   rsp      out        rsp_valid/rsp_ready    rsp_symbol[7:0], rsp_last, rsp_error
//
// A request yields the letters of its numeral (1 to 15), which the letter
// sequencer emits one letter per cycle while the response side does not
// stall; an error request yields one letter and a zero request none.
// Letters pass the second front stage, the queue and the response register.
// Synchronous reset empties the pipeline and the queue; no clearing pass.
// The front keeps taking requests while the sequencer or the response side
// stalls, until its four-entry queue and two stages are full.
// ----------------------------------------------------------------------------
module integer_to_roman_numeral import irn_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [15:0] req_number,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [7:0]  rsp_symbol,
   output logic        rsp_last,
   output logic        rsp_error
);

   logic     push_valid, push_ready;
   desc_type push_data;
   logic     head_valid, head_pop;
   desc_type head_data;

   irn_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_number (req_number),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data)
   );

   irn_fifo u_fifo (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data),
      .pop_valid  (head_valid),
      .pop_ready  (head_pop),
      .pop_data   (head_data)
   );

   irn_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head_pop   (head_pop),
      .head_data  (head_data),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_symbol (rsp_symbol),
      .rsp_last   (rsp_last),
      .rsp_error  (rsp_error)
   );

endmodule

FILE: rtl/core/irn_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// irn_front
// Two-stage front end: takes requests, flags errors, drops zero and splits
// the number into decimal digits by constant compares.
// ----------------------------------------------------------------------------
module irn_front import irn_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [15:0] req_number,
   output logic        push_valid,
   input  logic        push_ready,
   output desc_type    push_data
);

   logic        s1_valid_ff, s1_valid_in;
   logic [15:0] s1_num_ff;
   logic        s2_valid_ff, s2_valid_in;
   logic        s2_err_ff;
   logic [1:0]  s2_thou_ff;
   logic [9:0]  s2_rem_ff;

   logic        s1_go, s2_go, s2_free, s2_zero;
   logic        err_c;
   logic [1:0]  thou_c;
   logic [11:0] thou_sub_c;
   logic [9:0]  rem_c;
   logic [3:0]  hund_c, tens_c;
   logic [9:0]  hund_sub_c;
   logic [6:0]  rem2_c, tens_sub_c;

   // Stage 1 to 2: thousands.
   always_comb begin
      err_c      = (s1_num_ff >= NumLimit);
      thou_c     = 2'd0;
      thou_sub_c = 12'd0;
      for (int k = 1; k <= 3; k++) begin
         if (s1_num_ff >= 16'(k * 1000)) begin
            thou_c     = 2'(k);
            thou_sub_c = 12'(k * 1000);
         end
      end
      rem_c = 10'(s1_num_ff[11:0] - thou_sub_c);
   end

   // Stage 2 to queue: hundreds, tens and units.
   always_comb begin
      hund_c     = 4'd0;
      hund_sub_c = 10'd0;
      for (int k = 1; k <= 9; k++) begin
         if (s2_rem_ff >= 10'(k * 100)) begin
            hund_c     = 4'(k);
            hund_sub_c = 10'(k * 100);
         end
      end
      rem2_c     = 7'(s2_rem_ff - hund_sub_c);
      tens_c     = 4'd0;
      tens_sub_c = 7'd0;
      for (int k = 1; k <= 9; k++) begin
         if (rem2_c >= 7'(k * 10)) begin
            tens_c     = 4'(k);
            tens_sub_c = 7'(k * 10);
         end
      end
   end

   assign push_data.err  = s2_err_ff;
   assign push_data.thou = s2_thou_ff;
   assign push_data.hund = hund_c;
   assign push_data.tens = tens_c;
   assign push_data.unit = 4'(rem2_c - tens_sub_c);

   // A zero request yields nothing and leaves without a queue slot.
   assign s2_zero    = !s2_err_ff && (s2_thou_ff == 2'd0) && (s2_rem_ff == 10'd0);
   assign push_valid = s2_valid_ff && !s2_zero;
   assign s2_go      = s2_valid_ff && (s2_zero || push_ready);
   assign s2_free    = !s2_valid_ff || s2_go;
   assign s1_go      = s1_valid_ff && s2_free;
   assign req_ready  = !s1_valid_ff || s1_go;

   assign s1_valid_in = (req_valid && req_ready) || (s1_valid_ff && !s1_go);
   assign s2_valid_in = s1_go || (s2_valid_ff && !s2_go);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s2_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         s1_num_ff <= req_number;
      end
      if (s1_go) begin
         s2_err_ff  <= err_c;
         s2_thou_ff <= thou_c;
         s2_rem_ff  <= rem_c;
      end
   end

endmodule

FILE: rtl/core/irn_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// irn_fifo
// Small request queue between the front end and the letter sequencer.
// ----------------------------------------------------------------------------
module irn_fifo import irn_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     push_valid,
   output logic     push_ready,
   input  desc_type push_data,
   output logic     pop_valid,
   input  logic     pop_ready,
   output desc_type pop_data
);

   desc_type              slot_ff [FifoDepth];
   logic [FifoPtrW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [FifoPtrW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [FifoCntW-1:0]   count_ff, count_in;
   logic                  do_push, do_pop;

   assign push_ready = (count_ff != FifoCntW'(FifoDepth));
   assign pop_valid  = (count_ff != '0);
   assign pop_data   = slot_ff[rd_ptr_ff];

   assign do_push = push_valid && push_ready;
   assign do_pop  = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == FifoPtrW'(FifoDepth - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == FifoPtrW'(FifoDepth - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

FILE: rtl/core/irn_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// irn_back
// Letter sequencer: walks the digits of the queued request one letter per
// cycle into the response register, while the response side does not stall.
// ----------------------------------------------------------------------------
module irn_back import irn_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       head_valid,
   output logic       head_pop,
   input  desc_type   head_data,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [7:0] rsp_symbol,
   output logic       rsp_last,
   output logic       rsp_error
);

   logic [1:0] place_ff, place_in;
   logic [1:0] step_ff, step_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic [7:0] rsp_symbol_ff;
   logic       rsp_last_ff;
   logic       rsp_error_ff;

   logic [2:0] lens [NumPlaces];
   logic [3:0] digit_c;
   logic [1:0] cur_place, code_c;
   logic [2:0] cur_len;
   logic       more_after, last_in_place, emit, done_c;
   logic [7:0] sym_c;

   assign lens[PlaceThou] = {1'b0, head_data.thou};
   assign lens[PlaceHund] = digit_len(head_data.hund);
   assign lens[PlaceTens] = digit_len(head_data.tens);
   assign lens[PlaceUnit] = digit_len(head_data.unit);

   // The position may point at a place that has no letters; skip forward to
   // the first place at or after it that has some.
   always_comb begin
      cur_place = place_ff;
      for (int q = NumPlaces - 1; q >= 0; q--) begin
         if ((2'(q) >= place_ff) && (lens[q] != 3'd0)) begin
            cur_place = 2'(q);
         end
      end
      more_after = 1'b0;
      for (int q = 0; q < NumPlaces; q++) begin
         if ((2'(q) > cur_place) && (lens[q] != 3'd0)) begin
            more_after = 1'b1;
         end
      end
   end

   always_comb begin
      case (cur_place)
         PlaceHund: digit_c = head_data.hund;
         PlaceTens: digit_c = head_data.tens;
         PlaceUnit: digit_c = head_data.unit;
         default:   digit_c = 4'd0;
      endcase
   end

   assign cur_len       = lens[cur_place];
   assign code_c        = (cur_place == PlaceThou) ? CodeOne : digit_code(digit_c, step_ff);
   assign sym_c         = head_data.err ? SymErr : place_letter(cur_place, code_c);
   assign last_in_place = (({1'b0, step_ff} + 3'd1) == cur_len);
   assign done_c        = head_data.err || (last_in_place && !more_after);

   assign emit     = head_valid && (!rsp_valid_ff || rsp_ready);
   assign head_pop = emit && done_c;

   always_comb begin
      place_in = place_ff;
      step_in  = step_ff;
      if (emit) begin
         if (done_c) begin
            place_in = PlaceThou;
            step_in  = 2'd0;
         end else if (last_in_place) begin
            place_in = cur_place + 2'd1;
            step_in  = 2'd0;
         end else begin
            place_in = cur_place;
            step_in  = step_ff + 2'd1;
         end
      end
   end

   assign rsp_valid_in = emit || (rsp_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         place_ff     <= PlaceThou;
         step_ff      <= 2'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         place_ff     <= place_in;
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         rsp_symbol_ff <= sym_c;
         rsp_last_ff   <= done_c;
         rsp_error_ff  <= head_data.err;
      end
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_symbol = rsp_symbol_ff;
   assign rsp_last   = rsp_last_ff;
   assign rsp_error  = rsp_error_ff;

endmodule

FILE: test/irn_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// irn_checker
// Watches both channels of the Roman numeral converter. Every accepted
// request is turned into the letters it should produce. Each accepted
// response is checked against the oldest of those letters.
// ----------------------------------------------------------------------------
module irn_checker import irn_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_ready,
   input  logic [15:0] req_number,
   input  logic        rsp_valid,
   input  logic        rsp_ready,
   input  logic [7:0]  rsp_symbol,
   input  logic        rsp_last,
   input  logic        rsp_error,
   output int          mismatch_count,
   output int          pending_count,
   output int          request_count,
   output int          zero_count,
   output int          overrange_count,
   output int          letter_count
);

   typedef struct {
      logic [7:0] symbol;
      logic       last;
      logic       error;
   } letter_type;

   letter_type expected_letters[$];

   int mismatches = 0;
   int pending    = 0;
   int requests   = 0;
   int zeros      = 0;
   int overranges = 0;
   int letters    = 0;

   assign mismatch_count  = mismatches;
   assign pending_count   = pending;
   assign request_count   = requests;
   assign zero_count      = zeros;
   assign overrange_count = overranges;
   assign letter_count    = letters;

   // Letters of one lower decimal digit, given the letters of its place.
   function automatic string digit_text(input int unsigned d, input string one,
                                        input string five, input string ten);
      string       s;
      int unsigned k;
      s = "";
      case (d)
         4: s = {one, five};
         9: s = {one, ten};
         default: begin
            if (d >= 5) begin
               s = five;
               d = d - 5;
            end
            for (k = 0; k < d; k++) s = {s, one};
         end
      endcase
      return s;
   endfunction

   always @(posedge clock) begin
      string       text;
      int unsigned n;
      int unsigned k;
      letter_type  want;
      letter_type  item;
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            letters++;
            if (expected_letters.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("%0t: unexpected response symbol=%02h last=%b error=%b",
                           $realtime, rsp_symbol, rsp_last, rsp_error);
            end else begin
               want = expected_letters.pop_front();
               if (rsp_symbol !== want.symbol || rsp_last !== want.last ||
                   rsp_error !== want.error) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display({"%0t: response mismatch, expected symbol=%02h last=%b ",
                               "error=%b, got symbol=%02h last=%b error=%b"},
                              $realtime, want.symbol, want.last, want.error,
                              rsp_symbol, rsp_last, rsp_error);
               end
            end
         end
         if (req_valid && req_ready) begin
            requests++;
            n = req_number;
            if (req_number >= NumLimit) begin
               overranges++;
               item.symbol = SymErr;
               item.last   = 1'b1;
               item.error  = 1'b1;
               expected_letters.push_back(item);
            end else begin
               text = "";
               for (k = 0; k < n / 1000; k++) text = {text, "M"};
               text = {text, digit_text((n % 1000) / 100, "C", "D", "M"),
                       digit_text((n % 100) / 10, "X", "L", "C"),
                       digit_text(n % 10, "I", "V", "X")};
               // Zero leaves the text empty and expects nothing.
               if (text.len() == 0) zeros++;
               for (k = 0; k < text.len(); k++) begin
                  item.symbol = text[k];
                  item.last   = (k == text.len() - 1);
                  item.error  = 1'b0;
                  expected_letters.push_back(item);
               end
            end
         end
         pending = expected_letters.size();
      end
   end

endmodule

FILE: test/tb_integer_to_roman_numeral.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_integer_to_roman_numeral
// Drives numbers into the Roman numeral converter under several idle and
// stall profiles, including a long response hold-off, while a checker
// predicts and compares every letter that comes back.
// ----------------------------------------------------------------------------
module tb_integer_to_roman_numeral;
   import irn_pkg::*;

   localparam int StallLimit = 5000;
   localparam int HoldCycles = 300;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   logic [15:0] req_number;
   logic        rsp_valid;
   logic        rsp_ready;
   logic [7:0]  rsp_symbol;
   logic        rsp_last;
   logic        rsp_error;

   int mismatch_count;
   int pending_count;
   int request_count;
   int zero_count;
   int overrange_count;
   int letter_count;

   int req_idle_pct  = 0;
   int rsp_stall_pct = 0;
   int rsp_hold_left = 0;

   integer_to_roman_numeral i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_number (req_number),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_symbol (rsp_symbol),
      .rsp_last   (rsp_last),
      .rsp_error  (rsp_error)
   );

   irn_checker i_checker (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_number      (req_number),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_symbol      (rsp_symbol),
      .rsp_last        (rsp_last),
      .rsp_error       (rsp_error),
      .mismatch_count  (mismatch_count),
      .pending_count   (pending_count),
      .request_count   (request_count),
      .zero_count      (zero_count),
      .overrange_count (overrange_count),
      .letter_count    (letter_count)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // The receiver either holds off for a counted stretch or stalls at random.
   initial begin
      forever begin
         @(negedge clock);
         if (rsp_hold_left > 0) begin
            rsp_ready     <= 1'b0;
            rsp_hold_left <= rsp_hold_left - 1;
         end else begin
            rsp_ready <= ($urandom_range(99) >= rsp_stall_pct);
         end
      end
   end

   initial begin : watchdog
      int quiet;
      quiet = 0;
      while (quiet < StallLimit) begin
         @(posedge clock);
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) quiet = 0;
         else quiet++;
      end
      $display("Timeout: nothing accepted for %0d cycles", StallLimit);
      $display("Verification failed");
      $finish;
   end

   // Entered and left at a falling edge; valid stays high on the way out.
   task automatic send_request(input logic [15:0] n);
      while ($urandom_range(99) < req_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid  <= 1'b1;
      req_number <= n;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      @(negedge clock);
   endtask

   // Profile changes land on a rising edge, away from the receiver process.
   task automatic set_profile(input int idle_pct, input int stall_pct, input int hold);
      req_valid <= 1'b0;
      @(posedge clock);
      req_idle_pct  = idle_pct;
      rsp_stall_pct = stall_pct;
      rsp_hold_left = hold;
      @(negedge clock);
   endtask

   task automatic wait_for_drain();
      req_valid <= 1'b0;
      while (pending_count != 0) @(negedge clock);
   endtask

   // Mostly valid numbers, with some zeros and out-of-range values.
   function automatic logic [15:0] random_number();
      int unsigned r;
      r = $urandom_range(99);
      if (r < 5) return 16'd0;
      if (r < 18) return 16'($urandom_range(65535, 4000));
      return 16'($urandom_range(3999, 1));
   endfunction

   logic [15:0] directed_numbers[25] = '{
      16'd1, 16'd2, 16'd3, 16'd4, 16'd5, 16'd8, 16'd9, 16'd10, 16'd14, 16'd40,
      16'd49, 16'd90, 16'd99, 16'd400, 16'd444, 16'd500, 16'd900, 16'd999,
      16'd1000, 16'd3888, 16'd3999, 16'd4000, 16'd65535, 16'd0, 16'd32768
   };
   int idle_profile[4]  = '{0, 57, 0, 26};
   int stall_profile[4] = '{0, 0, 57, 26};

   initial begin
      int p;
      int i;
      req_valid  = 1'b0;
      req_number = 16'd0;
      rsp_ready  = 1'b0;
      reset      = 1'b1;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      foreach (directed_numbers[k]) send_request(directed_numbers[k]);

      // Hold the response side so the queue fills and the input backs up.
      set_profile(0, 0, HoldCycles);
      for (i = 0; i < 24; i++) send_request(random_number());
      wait_for_drain();

      for (p = 0; p < 4; p++) begin
         set_profile(idle_profile[p], stall_profile[p], 0);
         for (i = 0; i < 55; i++) send_request(random_number());
      end

      wait_for_drain();
      repeat (20) @(negedge clock);

      $display("Converted %0d requests (%0d zero, %0d out of range) into %0d responses,",
               request_count, zero_count, overrange_count, letter_count);
      $display("under four idle profiles and a %0d-cycle response hold-off.", HoldCycles);
      if (pending_count != 0)
         $display("%0d expected responses never arrived", pending_count);
      if (mismatch_count == 0 && pending_count == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule

FILE: sim.f
rtl/core/irn_pkg.sv
rtl/core/irn_front.sv
rtl/core/irn_fifo.sv
rtl/core/irn_back.sv
rtl/core/integer_to_roman_numeral.sv
test/irn_checker.sv
test/tb_integer_to_roman_numeral.sv
